// ----- rtl/kct_pkg.sv -----
// Package for the keyed count table: types, codes and constants shared by
// the controller, the datapath and the top level. No dependencies.
`default_nettype none
package kct_pkg;

  localparam int KCT_ENTRIES = 64;
  localparam logic [6:0] CAP_RESET = 7'd64;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // Operation codes carried in the input word.
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REDUCE = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_BAD      = 3'd1;
  localparam logic [2:0] ST_ABSENT   = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic [31:0] key;
    logic [15:0] count;
    logic [15:0] slot;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_UPDATE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // latch the input word and restart the scan
    logic rd_en;   // read the table at the scan address and advance it
    logic commit;  // apply the operation and load the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic addr_last;  // scan address points at the last entry
    logic out_busy;   // result register full and not taken this cycle
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/keyed_count_table.sv -----
// Top level of the keyed count table: joins the controller and the datapath.
// Depends on kct_pkg, kct_ctrl and kct_dp.
`default_nettype none
//
//  Channel   Direction  Handshake                   Contents
//  s_axis    in         s_axis_tvalid/tready        operation word (cmd, key, amount)
//  m_axis    out        m_axis_tvalid/tready        result word (status, count, slot)
//  cfg       in         cfg_we, no back-pressure    capacity register
//
// Each input word passes through these steps in order: it is accepted, the
// entry memory is scanned through its single read port, the registered read
// drains and the update follows. No new word is accepted before that update.
// Reset is synchronous and active high; it empties the table, zeroes the
// slot counter and sets the capacity to 64. The table memory itself is not
// cleared, since per-entry valid bits guard every read. A stalled result
// word holds in the output register; the next input word is accepted
// meanwhile and waits in its update step until the register is free.
//
module keyed_count_table #(
  parameter int ENTRIES = kct_pkg::KCT_ENTRIES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Capacity register write.
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_wdata,
  // Input words.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // Fields from bit 0 up: cmd [1:0], item_key [33:2], amount [49:34], zero fill.
  input  wire logic [55:0] s_axis_tdata,
  // Result words.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // Fields from bit 0 up: status [2:0], count_now [18:3], slot_number [34:19],
  // zero fill.
  output logic [39:0]      m_axis_tdata
);
  import kct_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // The controller sequences accept, scan, drain and update; it sees the
  // datapath only through the command and status structs.
  kct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the table, the counters and the result register.
  kct_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (s_axis_tdata),
    .out_data  (m_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
`default_nettype wire

// ----- rtl/kct_ctrl.sv -----
// Controller state machine of the keyed count table.
// Depends on kct_pkg for the state type and the command and status structs.
`default_nettype none
module kct_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire kct_pkg::dp_stat_t  stat,
  output kct_pkg::ctrl_cmd_t      cmd
);
  import kct_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (stat.addr_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        if (!stat.out_busy) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.rd_en  = 1'b0;
    cmd.commit = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
      end
      S_DRAIN: begin
      end
      S_UPDATE: begin
        cmd.commit = !stat.out_busy;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/kct_dp.sv -----
// Datapath of the keyed count table: entry memory, valid bits, scan
// compare, update arithmetic and result register. Depends on kct_pkg.
`default_nettype none
module kct_dp #(
  parameter int ENTRIES = kct_pkg::KCT_ENTRIES
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [6:0]         cfg_wdata,
  input  wire logic [55:0]        in_data,
  output logic [39:0]             out_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire kct_pkg::ctrl_cmd_t cmd,
  output kct_pkg::dp_stat_t       stat
);
  import kct_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OW = $clog2(ENTRIES + 1);
  localparam int LW = (OW > 7) ? OW : 7;

  entry_t         mem [ENTRIES];
  logic           valid [ENTRIES];

  logic [6:0]     capacity;
  logic [OW-1:0]  occupied;
  logic [15:0]    next_slot;

  logic [1:0]     op;
  logic [31:0]    key;
  logic [15:0]    amt;

  logic [IW-1:0]  addr;
  logic           chk;
  logic [IW-1:0]  chk_idx;
  logic           chk_valid;
  entry_t         rd_q;

  logic           hit;
  logic [IW-1:0]  hit_idx;
  logic [15:0]    hit_cnt;
  logic [15:0]    hit_slot;
  logic           free_found;
  logic [IW-1:0]  free_idx;

  // Update decision.
  logic [LW-1:0]  limit;
  logic [16:0]    sum;
  logic [15:0]    diff;
  logic [2:0]     res_status;
  logic [15:0]    res_count;
  logic [15:0]    res_slot;
  logic           wr_en;
  logic [IW-1:0]  wr_idx;
  entry_t         wr_entry;
  logic           v_set;
  logic           v_clr;
  logic           occ_inc;
  logic           occ_dec;
  logic           slot_inc;
  logic           clear_all;

  assign stat.addr_last = (addr == IW'(ENTRIES - 1));
  assign stat.out_busy  = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= in_data[1:0];
      key <= in_data[33:2];
      amt <= in_data[49:34];
    end
  end

  // Scan address and registered memory read.
  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
      chk  <= 1'b0;
    end else begin
      chk <= cmd.rd_en;
      if (cmd.load) begin
        addr <= '0;
      end else if (cmd.rd_en) begin
        addr <= addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_q      <= mem[addr];
      chk_idx   <= addr;
      chk_valid <= valid[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
  end

  // Match and first-free tracking over the scan.
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else if (chk) begin
      if (chk_valid && (rd_q.key == key) && (key != 32'd0)) begin
        hit <= 1'b1;
      end
      if (!chk_valid && !free_found) begin
        free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (chk) begin
      if (chk_valid && (rd_q.key == key)) begin
        hit_idx  <= chk_idx;
        hit_cnt  <= rd_q.count;
        hit_slot <= rd_q.slot;
      end
      if (!chk_valid && !free_found) begin
        free_idx <= chk_idx;
      end
    end
  end

  always_comb begin
    if (capacity == 7'd0) begin
      limit = LW'(1);
    end else if (LW'(capacity) > LW'(ENTRIES)) begin
      limit = LW'(ENTRIES);
    end else begin
      limit = LW'(capacity);
    end
  end

  assign sum  = {1'b0, hit_cnt} + {1'b0, amt};
  assign diff = hit_cnt - amt;

  always_comb begin
    res_status = ST_DONE;
    res_count  = hit ? hit_cnt : 16'd0;
    res_slot   = hit ? hit_slot : 16'd0;
    wr_en      = 1'b0;
    wr_idx     = hit_idx;
    wr_entry   = '{key: key, count: sum[15:0], slot: hit_slot};
    v_set      = 1'b0;
    v_clr      = 1'b0;
    occ_inc    = 1'b0;
    occ_dec    = 1'b0;
    slot_inc   = 1'b0;
    clear_all  = 1'b0;
    if (op == OP_CLEAR) begin
      clear_all = 1'b1;
      res_count = 16'd0;
      res_slot  = 16'd0;
    end else if ((op != OP_ADD && op != OP_REDUCE) || key == 32'd0 || amt == 16'd0) begin
      res_status = ST_BAD;
    end else if (op == OP_ADD) begin
      if (hit) begin
        if (sum[16]) begin
          res_status = ST_OVERFLOW;
        end else begin
          wr_en     = 1'b1;
          res_count = sum[15:0];
        end
      end else if (LW'(occupied) >= limit || !free_found) begin
        res_status = ST_FULL;
      end else begin
        wr_en     = 1'b1;
        wr_idx    = free_idx;
        wr_entry  = '{key: key, count: amt, slot: next_slot};
        v_set     = 1'b1;
        occ_inc   = 1'b1;
        slot_inc  = 1'b1;
        res_count = amt;
        res_slot  = next_slot;
      end
    end else begin
      if (!hit || hit_cnt < amt) begin
        res_status = ST_ABSENT;
      end else if (diff == 16'd0) begin
        v_clr     = 1'b1;
        occ_dec   = (occupied != '0);
        res_count = 16'd0;
        res_slot  = 16'd0;
      end else begin
        wr_en          = 1'b1;
        wr_entry.count = diff;
        res_count      = diff;
      end
    end
    wr_en = wr_en && cmd.commit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) valid[i] <= 1'b0;
      occupied  <= '0;
      next_slot <= 16'd0;
    end else if (cmd.commit) begin
      if (clear_all) begin
        for (int i = 0; i < ENTRIES; i++) valid[i] <= 1'b0;
        occupied  <= '0;
        next_slot <= 16'd0;
      end else begin
        if (v_set) valid[free_idx] <= 1'b1;
        if (v_clr) valid[hit_idx] <= 1'b0;
        if (occ_inc) occupied <= occupied + 1'b1;
        if (occ_dec) occupied <= occupied - 1'b1;
        if (slot_inc) next_slot <= next_slot + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data <= {5'd0, res_slot, res_count, res_status};
    end
  end

endmodule
`default_nettype wire

// ----- bench/tb_keyed_count_table.sv -----
`timescale 1ns / 1ps
// Testbench for keyed_count_table. It drives operation words, expects each result
// word from its own model of the table or as typed in, and checks each one in order.
// Depends on kct_pkg and on the keyed_count_table RTL.
module tb_keyed_count_table;
  import kct_pkg::*;

  localparam int CLK_HALF = 6;
  localparam int N_SLOTS = KCT_ENTRIES;
  localparam int N_PHASES = 9;
  localparam int ITEMS_PER_PHASE = 184;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int HOLD_CYCLES = 600;
  // Long enough for the block to finish a word, with margin on top.
  localparam int SETTLE_CYCLES = N_SLOTS + 8;
  // The command field has room for a fourth code that the block rejects.
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] count;
    logic [15:0] slot;
  } result_t;

  // One row of the directed table. When set_cap is high the capacity is
  // written, with the block idle, before the row's word is sent. When known
  // is high the typed-in result is expected instead of the predicted one.
  typedef struct packed {
    logic        set_cap;
    logic [6:0]  cap;
    logic [1:0]  op;
    logic [31:0] key;
    logic [15:0] amt;
    logic        known;
    result_t     want;
  } row_t;

  localparam row_t DIRECTED_ROWS [0:22] = '{
    // Zero key and zero amount are rejected on an empty table.
    '{1'b0, 7'd0, OP_ADD,    32'd0,          16'd5,     1'b1, '{ST_BAD, 16'd0, 16'd0}},
    '{1'b0, 7'd0, OP_ADD,    32'd1,          16'd0,     1'b1, '{ST_BAD, 16'd0, 16'd0}},
    // First allocations take slots 0 and 1.
    '{1'b0, 7'd0, OP_ADD,    32'd1,          16'd1,     1'b1, '{ST_DONE, 16'd1, 16'd0}},
    '{1'b0, 7'd0, OP_ADD,    32'hFFFF_FFFF,  16'hFFFF,  1'b1, '{ST_DONE, 16'hFFFF, 16'd1}},
    // A full count cannot take even one more.
    '{1'b0, 7'd0, OP_ADD,    32'hFFFF_FFFF,  16'd1,     1'b1, '{ST_OVERFLOW, 16'hFFFF, 16'd1}},
    '{1'b0, 7'd0, OP_ADD,    32'd1,          16'hFFFE,  1'b1, '{ST_DONE, 16'hFFFF, 16'd0}},
    '{1'b0, 7'd0, OP_REDUCE, 32'd2,          16'd1,     1'b1, '{ST_ABSENT, 16'd0, 16'd0}},
    // Reducing to zero frees the entry; a second reduce finds it absent.
    '{1'b0, 7'd0, OP_REDUCE, 32'd1,          16'hFFFF,  1'b1, '{ST_DONE, 16'd0, 16'd0}},
    '{1'b0, 7'd0, OP_REDUCE, 32'd1,          16'd1,     1'b1, '{ST_ABSENT, 16'd0, 16'd0}},
    // The unused command and a zero amount report the key as it stands.
    '{1'b0, 7'd0, OP_SPARE,  32'hFFFF_FFFF,  16'd1,     1'b1, '{ST_BAD, 16'hFFFF, 16'd1}},
    '{1'b0, 7'd0, OP_REDUCE, 32'hFFFF_FFFF,  16'd0,     1'b1, '{ST_BAD, 16'hFFFF, 16'd1}},
    '{1'b0, 7'd0, OP_REDUCE, 32'd0,          16'd0,     1'b1, '{ST_BAD, 16'd0, 16'd0}},
    // A freed key comes back with a new slot number.
    '{1'b0, 7'd0, OP_ADD,    32'd1,          16'd7,     1'b1, '{ST_DONE, 16'd7, 16'd2}},
    '{1'b0, 7'd0, OP_ADD,    32'hA5A5_5A5A,  16'h5A5A,  1'b0, '{ST_DONE, 16'd0, 16'd0}},
    // A clear empties the table and restarts the slot numbers.
    '{1'b0, 7'd0, OP_CLEAR,  32'd0,          16'd0,     1'b1, '{ST_DONE, 16'd0, 16'd0}},
    '{1'b0, 7'd0, OP_ADD,    32'd5,          16'd3,     1'b1, '{ST_DONE, 16'd3, 16'd0}},
    '{1'b0, 7'd0, OP_REDUCE, 32'hFFFF_FFFF,  16'd1,     1'b1, '{ST_ABSENT, 16'd0, 16'd0}},
    '{1'b0, 7'd0, OP_REDUCE, 32'd5,          16'd4,     1'b1, '{ST_ABSENT, 16'd3, 16'd0}},
    // Capacity zero acts as one, and one key is already held.
    '{1'b1, 7'd0, OP_ADD,    32'd10,         16'd1,     1'b1, '{ST_FULL, 16'd0, 16'd0}},
    '{1'b0, 7'd0, OP_REDUCE, 32'd5,          16'd3,     1'b1, '{ST_DONE, 16'd0, 16'd0}},
    '{1'b0, 7'd0, OP_ADD,    32'd10,         16'd2,     1'b1, '{ST_DONE, 16'd2, 16'd1}},
    '{1'b0, 7'd0, OP_ADD,    32'd11,         16'd1,     1'b1, '{ST_FULL, 16'd0, 16'd0}},
    // Capacity above the table size saturates, so a second key fits again.
    '{1'b1, 7'd127, OP_ADD,  32'd11,         16'd1,     1'b1, '{ST_DONE, 16'd1, 16'd2}}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [6:0]  cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  // The table as the testbench expects it to be after every accepted word.
  logic        tbl_valid [N_SLOTS];
  logic [31:0] tbl_key   [N_SLOTS];
  logic [15:0] tbl_count [N_SLOTS];
  logic [15:0] tbl_slot  [N_SLOTS];
  logic [15:0] slot_next;
  int          keys_held;
  logic [6:0]  cap_reg;

  result_t     expected_results [$];
  logic [31:0] key_pool [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int holds_done = 0;
  int hold_left = 0;
  int mismatches = 0;
  int cycle_count = 0;

  keyed_count_table i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #CLK_HALF clk = ~clk;

  function automatic int key_limit();
    if (cap_reg == 7'd0) return 1;
    if (cap_reg > N_SLOTS) return N_SLOTS;
    return int'(cap_reg);
  endfunction

  function automatic int find_entry(input logic [31:0] k);
    if (k == 32'd0) return -1;
    for (int i = 0; i < N_SLOTS; i++)
      if (tbl_valid[i] && tbl_key[i] == k) return i;
    return -1;
  endfunction

  // Applies one operation to the predicted table and returns the result word
  // the block should give for it.
  function automatic result_t count_table_step(input logic [1:0] op, input logic [31:0] k,
                                               input logic [15:0] a);
    result_t r;
    int      at;
    int      sum;
    r = '{ST_DONE, 16'd0, 16'd0};
    if (op == OP_CLEAR) begin
      for (int i = 0; i < N_SLOTS; i++) tbl_valid[i] = 1'b0;
      keys_held = 0;
      slot_next = 16'd0;
      return r;
    end
    at = find_entry(k);
    if (op == OP_SPARE || k == 32'd0 || a == 16'd0) begin
      r.status = ST_BAD;
    end else if (op == OP_ADD) begin
      if (at >= 0) begin
        sum = int'(tbl_count[at]) + int'(a);
        if (sum > int'(COUNT_MAX)) r.status = ST_OVERFLOW;
        else tbl_count[at] = sum[15:0];
      end else if (keys_held >= key_limit()) begin
        r.status = ST_FULL;
      end else begin
        for (int i = 0; i < N_SLOTS; i++)
          if (at < 0 && !tbl_valid[i]) at = i;
        if (at < 0) begin
          r.status = ST_FULL;
        end else begin
          tbl_valid[at] = 1'b1;
          tbl_key[at]   = k;
          tbl_count[at] = a;
          tbl_slot[at]  = slot_next;
          slot_next     = slot_next + 16'd1;  // wraps from 0xFFFF to 0
          keys_held++;
        end
      end
    end else begin
      if (at < 0 || tbl_count[at] < a) begin
        r.status = ST_ABSENT;
      end else begin
        tbl_count[at] = tbl_count[at] - a;
        if (tbl_count[at] == 16'd0) begin
          tbl_valid[at] = 1'b0;
          if (keys_held > 0) keys_held--;
          at = -1;
        end
      end
    end
    if (at >= 0 && tbl_valid[at]) begin
      r.count = tbl_count[at];
      r.slot  = tbl_slot[at];
    end
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [15:0] want,
                               input logic [15:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in %s: expected %0h, got %0h", what, want, got);
  endtask

  // Offers one word, with a random gap first, and returns at the edge that
  // accepts it. The valid stays high so back-to-back words need no toggle.
  task automatic send_word(input logic [1:0] op, input logic [31:0] k,
                           input logic [15:0] a);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, a, k, op};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Stops offering words, waits for every expected result word and then for
  // the block's own latency, so that it is idle afterwards.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [6:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we  <= 1'b0;
    cap_reg = v;
  endtask

  // Result side: checks every accepted result word against the oldest
  // expectation and drives tready, either at random or held low for a long
  // stretch when the stimulus asks for one.
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tdata[2:0];
      got.count  = m_axis_tdata[18:3];
      got.slot   = m_axis_tdata[34:19];
      if (expected_results.size() == 0) begin
        note_mismatch("unexpected result word (status)", 16'd0, {13'd0, got.status});
      end else begin
        want = expected_results.pop_front();
        if (got.status != want.status)
          note_mismatch("status", {13'd0, want.status}, {13'd0, got.status});
        if (got.count != want.count) note_mismatch("count_now", want.count, got.count);
        if (got.slot != want.slot) note_mismatch("slot_number", want.slot, got.slot);
      end
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (hold_requests != holds_done) begin
      m_axis_tready <= 1'b0;
      hold_left = HOLD_CYCLES;
      holds_done++;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    row_t        row;
    logic [1:0]  op;
    logic [31:0] k;
    logic [15:0] a;
    int          at;
    int          hit;
    int          base;
    int          sel;
    int          pick;
    int          pool_size;

    for (int i = 0; i < N_SLOTS; i++) tbl_valid[i] = 1'b0;
    slot_next = 16'd0;
    keys_held = 0;
    cap_reg   = CAP_RESET;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, with light sender gaps and a busy receiver.
    send_idle_pct = 16;
    recv_idle_pct = 71;
    foreach (DIRECTED_ROWS[i]) begin
      row = DIRECTED_ROWS[i];
      if (row.set_cap) write_capacity(row.cap);
      if (row.known) begin
        void'(count_table_step(row.op, row.key, row.amt));
        expected_results = {expected_results, row.want};
      end else begin
        expected_results = {expected_results, count_table_step(row.op, row.key, row.amt)};
      end
      send_word(row.op, row.key, row.amt);
    end

    // Random part. Each phase sets a capacity without clearing the table, so
    // a lowered capacity often leaves more keys held than it allows.
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: write_capacity(7'd127);
        1: write_capacity(7'd5);
        2: write_capacity(7'd64);
        3: write_capacity(7'd0);
        4: write_capacity(7'($urandom_range(2, 63)));
        5: write_capacity(7'd100);
        6: write_capacity(7'd1);
        7: write_capacity(7'($urandom_range(65, 126)));
        default: write_capacity(7'd33);
      endcase
      if (p < 3) begin
        send_idle_pct = 16;
        recv_idle_pct = 71;
      end else if (p < 6) begin
        send_idle_pct = 71;
        recv_idle_pct = 16;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // A pool slightly larger than the capacity keeps the table near full,
      // so that hits, refusals and frees all happen often.
      key_pool.delete();
      pool_size = key_limit() + 8;
      for (int j = 0; j < pool_size; j++) begin
        k = $urandom;
        key_pool = {key_pool, ((k == 32'd0) ? 32'd1 : k)};
      end
      // The receiver stops for a long stretch while words keep coming.
      if (p == 6) hold_requests++;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 4 && n == ITEMS_PER_PHASE / 2) wait_drained();
        sel = $urandom_range(0, 99);
        k   = key_pool[$urandom_range(0, key_pool.size() - 1)];
        op  = OP_ADD;
        a   = 16'($urandom_range(1, 300));
        at  = find_entry(k);
        if (sel < 2) begin
          op = OP_CLEAR;
          k  = $urandom;
          a  = 16'($urandom);
        end else if (sel < 6) begin
          // Noise: any command, often a zero key or zero amount.
          op = 2'($urandom_range(0, 3));
          k  = ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom;
          a  = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
        end else if (sel < 56) begin
          pick = $urandom_range(0, 19);
          if (pick < 3) a = 16'($urandom_range(16'h8000, 16'hFFFF));
          else if (pick < 5) a = 16'($urandom);
          else if (pick < 7 && at >= 0 && tbl_count[at] != COUNT_MAX)
            a = COUNT_MAX - tbl_count[at];  // lands exactly on the top count
        end else begin
          op = OP_REDUCE;
          if ($urandom_range(0, 9) < 7) begin
            // Reduce a key that is held, often down to zero.
            hit  = -1;
            base = $urandom_range(0, N_SLOTS - 1);
            for (int j = 0; j < N_SLOTS; j++)
              if (hit < 0 && tbl_valid[(base + j) % N_SLOTS]) hit = (base + j) % N_SLOTS;
            if (hit >= 0) begin
              k = tbl_key[hit];
              a = ($urandom_range(0, 1) == 0) ? tbl_count[hit]
                                              : 16'($urandom_range(1, tbl_count[hit]));
            end
          end else begin
            a = 16'($urandom_range(1, 400));
          end
        end
        expected_results = {expected_results, count_table_step(op, k, a)};
        send_word(op, k, a);
      end
    end

    wait_drained();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
